### rtl/core/c33_pkg.sv
// shared types and constants of the 3x3 convolution block
// no dependencies
package c33_pkg;

    localparam int C_TAPS      = 9;
    localparam int C_POS_W     = 12;
    localparam int C_PROD_W    = 32;
    localparam int C_ACC_W     = 40;
    localparam int C_MAX_WIDTH  = 128;
    localparam int C_MAX_HEIGHT = 128;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_STRIDE   = 2'd2,
        CFG_CHANNELS = 2'd3
    } t_cfg_idx;

    // one window job handed from front to back
    typedef struct packed {
        logic [C_TAPS-1:0][C_PROD_W-1:0] prod;
        logic [C_POS_W-1:0]              ox;
        logic [C_POS_W-1:0]              oy;
        logic [15:0]                     bias;
        logic                            first;
        logic                            emit;
        logic                            last;
    } t_job;

endpackage

### rtl/core/c33_front.sv
// front part: config, taps, line buffers, window, products per window pixel
// depends on c33_pkg
module c33_front #(
    parameter int MAX_WIDTH  = c33_pkg::C_MAX_WIDTH,
    parameter int MAX_HEIGHT = c33_pkg::C_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [12:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_operation,
    input  logic [3:0]           i_tap_index,
    input  logic signed [15:0]   i_value,
    input  logic                 i_q_full,
    output logic                 o_push,
    output c33_pkg::t_job        o_job
);
    import c33_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [7:0]  r_cfg_w, r_cfg_h;
    logic        r_cfg_s;
    logic [12:0] r_cfg_ch;

    logic signed [15:0] r_tap [C_TAPS];
    logic signed [15:0] r_bias;
    logic signed [15:0] r_win [6];
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [11:0]        r_chan;
    logic [31:0]        r_line_rd;
    logic [31:0]        line_mem [MAX_WIDTH];
    logic               r_f_valid;
    t_job               r_job;

    logic          accept, is_pixel, in_plane, win_hit;
    logic [CW-1:0] w, out_w, n_col;
    logic [RW-1:0] h, out_h, n_row;
    logic [12:0]   ch_cnt;
    logic [11:0]   n_chan;
    logic [C_POS_W-1:0] ox, oy;
    logic signed [15:0] col3 [3];
    logic [C_TAPS-1:0][C_PROD_W-1:0] prod;

    assign o_stall = r_f_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_f_valid && !i_q_full;
    assign o_job   = r_job;

    // clamped geometry
    always_comb begin
        int iw, ih, ic;
        iw = int'(r_cfg_w);
        ih = int'(r_cfg_h);
        ic = int'(r_cfg_ch);
        if (iw < 3) iw = 3;
        if (iw > MAX_WIDTH) iw = MAX_WIDTH;
        if (ih < 3) ih = 3;
        if (ih > MAX_HEIGHT) ih = MAX_HEIGHT;
        if (ic < 1) ic = 1;
        if (ic > 4096) ic = 4096;
        w      = CW'(iw);
        h      = RW'(ih);
        ch_cnt = 13'(ic);
        out_w  = r_cfg_s ? CW'(((w - CW'(3)) >> 1) + CW'(1)) : CW'(w - CW'(2));
        out_h  = r_cfg_s ? RW'(((h - RW'(3)) >> 1) + RW'(1)) : RW'(h - RW'(2));
    end

    // classification and position advance
    always_comb begin
        is_pixel = (i_operation == OP_PIXEL);
        in_plane = (r_row < h) && (r_col < w);
        win_hit  = is_pixel && in_plane && (r_row >= RW'(2)) && (r_col >= CW'(2))
                   && (!r_cfg_s || (!r_row[0] && !r_col[0]));
        ox = C_POS_W'((r_col - CW'(2)) >> r_cfg_s);
        oy = C_POS_W'((r_row - RW'(2)) >> r_cfg_s);
        n_col  = r_col;
        n_row  = r_row;
        n_chan = r_chan;
        if (accept && i_operation == OP_BIAS) begin
            n_col  = '0;
            n_row  = '0;
            n_chan = '0;
        end else if (accept && is_pixel) begin
            if (CW'(r_col + CW'(1)) >= w) begin
                n_col = '0;
                if (RW'(r_row + RW'(1)) >= h) begin
                    n_row = '0;
                    if (13'(r_chan) + 13'd1 >= ch_cnt) n_chan = '0;
                    else n_chan = 12'(r_chan + 12'd1);
                end else begin
                    n_row = RW'(r_row + RW'(1));
                end
            end else begin
                n_col = CW'(r_col + CW'(1));
            end
        end
    end

    // window products
    always_comb begin
        col3[0] = $signed(r_line_rd[31:16]);
        col3[1] = $signed(r_line_rd[15:0]);
        col3[2] = i_value;
        for (int i = 0; i < 3; i++) begin
            prod[i*3+0] = C_PROD_W'(r_tap[i*3+0] * r_win[i]);
            prod[i*3+1] = C_PROD_W'(r_tap[i*3+1] * r_win[3+i]);
            prod[i*3+2] = C_PROD_W'(r_tap[i*3+2] * col3[i]);
        end
    end

    // line buffer: prefetch the next column, write on an in-plane pixel
    always_ff @(posedge i_clk) begin
        r_line_rd <= line_mem[n_col[AW-1:0]];
        if (accept && is_pixel && in_plane) begin
            line_mem[r_col[AW-1:0]] <= {r_line_rd[15:0], i_value};
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= 8'd128;
            r_cfg_h   <= 8'd128;
            r_cfg_s   <= 1'b0;
            r_cfg_ch  <= 13'd1;
            r_bias    <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_chan    <= '0;
            r_f_valid <= 1'b0;
            for (int i = 0; i < C_TAPS; i++) r_tap[i] <= '0;
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:    r_cfg_w  <= i_cfg_data[7:0];
                    CFG_HEIGHT:   r_cfg_h  <= i_cfg_data[7:0];
                    CFG_STRIDE:   r_cfg_s  <= i_cfg_data[0];
                    CFG_CHANNELS: r_cfg_ch <= i_cfg_data;
                    default:      r_cfg_s  <= r_cfg_s;
                endcase
            end
            r_col  <= n_col;
            r_row  <= n_row;
            r_chan <= n_chan;
            if (accept && i_operation == OP_WEIGHT && i_tap_index < 4'(C_TAPS)) begin
                r_tap[i_tap_index] <= i_value;
            end
            if (accept && i_operation == OP_BIAS) r_bias <= i_value;
            if (accept && is_pixel && in_plane) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= col3[0];
                r_win[4] <= col3[1];
                r_win[5] <= col3[2];
            end
            if (accept) r_f_valid <= win_hit;
            else if (o_push) r_f_valid <= 1'b0;
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (accept && win_hit) begin
            r_job.prod  <= prod;
            r_job.ox    <= ox;
            r_job.oy    <= oy;
            r_job.bias  <= r_bias;
            r_job.first <= (r_chan == '0);
            r_job.emit  <= (13'(r_chan) == ch_cnt - 13'd1);
            r_job.last  <= (oy == C_POS_W'(out_h - RW'(1))) && (ox == C_POS_W'(out_w - CW'(1)));
        end
    end

endmodule

### rtl/core/c33_queue.sv
// two-entry job queue between front and back
// depends on c33_pkg
module c33_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  c33_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output c33_pkg::t_job o_job
);
    import c33_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

endmodule

### rtl/core/c33_back.sv
// back part: window sum, accumulator read-modify-write, rounding, output register
// depends on c33_pkg
module c33_back #(
    parameter int MAX_WIDTH  = c33_pkg::C_MAX_WIDTH,
    parameter int MAX_HEIGHT = c33_pkg::C_MAX_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  c33_pkg::t_job       i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_result_value,
    output logic [6:0]          o_out_row,
    output logic [6:0]          o_out_col,
    output logic                o_plane_last
);
    import c33_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int IW    = $clog2(DEPTH);
    localparam logic signed [40:0] ACC_MAX = 41'sh0_7F_FFFF_FFFF;
    localparam logic signed [40:0] ACC_MIN = -ACC_MAX - 41'sd1;

    logic signed [C_ACC_W-1:0] acc_mem [DEPTH];

    logic                      en;
    logic                      r_b1_v, r_b2_v, r_b3_v, r_o_v;
    logic signed [33:0]        r_s [3];
    logic signed [C_ACC_W-1:0] r_rd;
    logic signed [35:0]        r_sum;
    logic signed [C_ACC_W-1:0] r_base, r_acc, n_acc;
    logic [IW-1:0]             idx_q, r_idx1, r_idx2, r_idx3;
    logic [C_POS_W-1:0]        r_ox1, r_oy1, r_ox2, r_oy2, r_ox3, r_oy3;
    logic                      r_emit1, r_emit2, r_emit3;
    logic                      r_last1, r_last2, r_last3;
    logic                      r_first1;
    logic [15:0]               r_bias1;
    logic signed [40:0]        wide;
    logic signed [40:0]        rnd;
    logic signed [26:0]        q;
    logic signed [15:0]        n_res;

    assign en    = !r_o_v || !i_stall;
    assign o_pop = en && !i_empty;
    assign idx_q = IW'(int'(i_job.oy) * MAX_WIDTH + int'(i_job.ox));
    assign o_valid = r_o_v;

    // accumulate with saturation, then round half up and clip to q8.8
    always_comb begin
        wide = 41'(r_base) + 41'(r_sum);
        if (wide > ACC_MAX) n_acc = C_ACC_W'(ACC_MAX);
        else if (wide < ACC_MIN) n_acc = C_ACC_W'(ACC_MIN);
        else n_acc = C_ACC_W'(wide);
        rnd = 41'(r_acc) + 41'sd8192;
        q   = 27'(rnd >>> 14);
        if (q > 27'sd32767) n_res = 16'sh7FFF;
        else if (q < -27'sd32768) n_res = 16'sh8000;
        else n_res = 16'(q);
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (en) begin
            r_b1_v <= !i_empty;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
            r_o_v  <= r_b3_v && r_emit3;
        end
    end

    // accumulator store: read at queue head, write back from the second stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd <= acc_mem[idx_q];
            if (r_b2_v) acc_mem[r_idx2] <= n_acc;
        end
    end

    // pipeline payload; the base forwards sums not yet visible in the store
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int g = 0; g < 3; g++) begin
                r_s[g] <= 34'($signed(i_job.prod[g*3])) + 34'($signed(i_job.prod[g*3+1]))
                          + 34'($signed(i_job.prod[g*3+2]));
            end
            r_idx1   <= idx_q;
            r_ox1    <= i_job.ox;
            r_oy1    <= i_job.oy;
            r_emit1  <= i_job.emit;
            r_last1  <= i_job.last;
            r_first1 <= i_job.first;
            r_bias1  <= i_job.bias;

            r_sum   <= 36'(r_s[0]) + 36'(r_s[1]) + 36'(r_s[2]);
            if (r_first1) r_base <= C_ACC_W'($signed(r_bias1)) <<< 14;
            else if (r_b2_v && r_idx2 == r_idx1) r_base <= n_acc;
            else if (r_b3_v && r_idx3 == r_idx1) r_base <= r_acc;
            else r_base <= r_rd;
            r_idx2  <= r_idx1;
            r_ox2   <= r_ox1;
            r_oy2   <= r_oy1;
            r_emit2 <= r_emit1;
            r_last2 <= r_last1;

            r_acc   <= n_acc;
            r_idx3  <= r_idx2;
            r_ox3   <= r_ox2;
            r_oy3   <= r_oy2;
            r_emit3 <= r_emit2;
            r_last3 <= r_last2;

            o_result_value <= n_res;
            o_out_row      <= r_oy3[6:0];
            o_out_col      <= r_ox3[6:0];
            o_plane_last   <= r_last3;
        end
    end

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && i_stall) |=> (r_o_v && $stable(o_result_value)))
        else $error("stalled result lost");
    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !(r_o_v && i_stall)) else $error("pop while output blocked");
    a_result_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_o_v)) |-> $past(r_b3_v)) else $error("result without job");

endmodule

### rtl/core/conv3x3_stride1_or_2_accumulate.sv
// top level of the 3x3 convolution with stride 1 or 2 and plane accumulation
// depends on c33_pkg, c33_front, c33_queue, c33_back
//
// Input channel (i_valid / o_stall): one item per transfer. Operation weight
// loads one tap, bias starts an output plane, pixel streams raster order.
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data, by the user only while the block is idle; the block does not enforce it.
// Output channel (o_valid / i_stall): one result per finished output pixel
// during the last configured input plane, with row, column and plane-last flag.
// Throughput: one item per cycle; every item is taken in its cycle unless
// the job queue is full and the front register holds a window job.
// Path: a window pixel passes the front product register, the queue, three back
// stages with the accumulator read-modify-write and then the output register.
// The accumulator store needs no clearing pass: the first plane of a sum takes
// the bias in place of the stored value.
// Reset: config to its reset values, taps, bias, window and counters zero,
// queue and pipeline empty. When the receiver stalls, the back pipeline holds,
// the queue fills and then o_stall rises.
module conv3x3_stride1_or_2_accumulate #(
    parameter int MAX_WIDTH  = c33_pkg::C_MAX_WIDTH,
    parameter int MAX_HEIGHT = c33_pkg::C_MAX_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [3:0]         i_tap_index,
    input  logic signed [15:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_result_value,
    output logic [6:0]         o_out_row,
    output logic [6:0]         o_out_col,
    output logic               o_plane_last
);
    import c33_pkg::*;

    t_job f_job, q_job;
    logic push, pop, q_full, q_empty;

    // front: accept and classify
    c33_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .o_stall, .i_operation, .i_tap_index, .i_value,
        .i_q_full(q_full), .o_push(push), .o_job(f_job)
    );

    // job queue
    c33_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(f_job), .o_full(q_full),
        .i_pop(pop), .o_empty(q_empty), .o_job(q_job)
    );

    // back: accumulate and emit
    c33_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_job(q_job), .o_pop(pop),
        .o_valid, .i_stall, .o_result_value, .o_out_row, .o_out_col, .o_plane_last
    );

endmodule

### dv/c33_checker.sv
// checker for the 3x3 convolution block: follows config writes and input transfers,
// predicts each output pixel and compares the output transfers field by field
// depends on c33_pkg
module c33_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [3:0]         i_tap_index,
    input  logic signed [15:0] i_value,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [15:0] o_result_value,
    input  logic [6:0]         o_out_row,
    input  logic [6:0]         o_out_col,
    input  logic               o_plane_last,
    output int                 o_fail_count,
    output int                 o_pending
);
    import c33_pkg::*;

    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct packed {
        logic signed [15:0] value;
        logic [6:0]         row;
        logic [6:0]         col;
        logic               last;
    } t_out_pix;

    // shadow copy of the block state
    logic [7:0]         cfg_width;
    logic [7:0]         cfg_height;
    logic               cfg_stride2;
    logic [12:0]        cfg_channels;
    logic signed [15:0] taps [C_TAPS];
    logic signed [15:0] bias;
    logic signed [15:0] lines [2][C_MAX_WIDTH];
    logic signed [15:0] win [6];
    longint             acc_mem [C_MAX_WIDTH*C_MAX_HEIGHT];
    int                 pos_row;
    int                 pos_col;
    int                 chan;
    t_out_pix           expected_pixels[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    task automatic clear_state();
        cfg_width    = 8'd128;
        cfg_height   = 8'd128;
        cfg_stride2  = 1'b0;
        cfg_channels = 13'd1;
        bias         = '0;
        pos_row      = 0;
        pos_col      = 0;
        chan         = 0;
        foreach (taps[i]) taps[i] = '0;
        foreach (win[i]) win[i] = '0;
        foreach (lines[i, j]) lines[i][j] = '0;
        foreach (acc_mem[i]) acc_mem[i] = 0;
        expected_pixels.delete();
    endtask

    // one pixel through line buffers, window, accumulator and output rounding
    task automatic conv_pixel(logic signed [15:0] v);
        int w, h, nch, s, ow, oh, r, c, ox, oy, idx;
        logic signed [15:0] col3 [3];
        longint sum, a, q;
        t_out_pix e;
        w   = clamp(int'(cfg_width), 3, C_MAX_WIDTH);
        h   = clamp(int'(cfg_height), 3, C_MAX_HEIGHT);
        nch = clamp(int'(cfg_channels), 1, 4096);
        s   = cfg_stride2;
        ow  = s ? (w - 3) / 2 + 1 : w - 2;
        oh  = s ? (h - 3) / 2 + 1 : h - 2;
        r   = pos_row;
        c   = pos_col;
        if (r < h && c < w) begin
            col3[0] = lines[0][c];
            col3[1] = lines[1][c];
            col3[2] = v;
            lines[0][c] = col3[1];
            lines[1][c] = v;
            if (r >= 2 && c >= 2 && (s == 0 || ((r - 2) % 2 == 0 && (c - 2) % 2 == 0))) begin
                ox  = (c - 2) >> s;
                oy  = (r - 2) >> s;
                sum = 0;
                for (int i = 0; i < 3; i++) begin
                    sum += longint'(taps[i*3])   * longint'(win[i]);
                    sum += longint'(taps[i*3+1]) * longint'(win[3+i]);
                    sum += longint'(taps[i*3+2]) * longint'(col3[i]);
                end
                idx = oy * C_MAX_WIDTH + ox;
                a = acc_mem[idx] + sum;
                if (a > ACC_HI) a = ACC_HI;
                if (a < ACC_LO) a = ACC_LO;
                if (chan == nch - 1) begin
                    // round half up to q8.8 and saturate
                    q = (a + 8192) >>> 14;
                    if (q > 32767) q = 32767;
                    if (q < -32768) q = -32768;
                    e.value = q[15:0];
                    e.row   = oy[6:0];
                    e.col   = ox[6:0];
                    e.last  = (oy == oh - 1 && ox == ow - 1);
                    expected_pixels.push_back(e);
                    acc_mem[idx] = longint'(bias) * 16384;
                end else begin
                    acc_mem[idx] = a;
                end
            end
            for (int i = 0; i < 3; i++) begin
                win[i]   = win[3+i];
                win[3+i] = col3[i];
            end
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
                chan++;
                if (chan >= nch) chan = 0;
            end
        end
        pos_row = r;
        pos_col = c;
    endtask

    task automatic apply_item(t_op op, logic [3:0] tap, logic signed [15:0] v);
        case (op)
            OP_WEIGHT: begin
                if (tap < C_TAPS) taps[tap] = v;
            end
            OP_BIAS: begin
                bias = v;
                foreach (acc_mem[i]) acc_mem[i] = longint'(v) * 16384;
                pos_row = 0;
                pos_col = 0;
                chan    = 0;
            end
            OP_PIXEL: conv_pixel(v);
            default: ;
        endcase
    endtask

    task automatic check_pixel();
        t_out_pix e;
        if (expected_pixels.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("unexpected output transfer: value %0d row %0d col %0d last %0b",
                         o_result_value, o_out_row, o_out_col, o_plane_last);
            return;
        end
        e = expected_pixels.pop_front();
        if (o_result_value !== e.value || o_out_row !== e.row || o_out_col !== e.col
                || o_plane_last !== e.last) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("mismatch: exp value %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                         e.value, e.row, e.col, e.last,
                         o_result_value, o_out_row, o_out_col, o_plane_last);
        end
    endtask

    // sample both channels and the config port at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (o_valid && !i_stall) check_pixel();
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH:    cfg_width    = i_cfg_data[7:0];
                    CFG_HEIGHT:   cfg_height   = i_cfg_data[7:0];
                    CFG_STRIDE:   cfg_stride2  = i_cfg_data[0];
                    CFG_CHANNELS: cfg_channels = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) apply_item(t_op'(i_operation), i_tap_index, i_value);
        end
        o_pending = expected_pixels.size();
    end

endmodule

### dv/tb_conv3x3_stride1_or_2_accumulate.sv
// testbench top for the 3x3 convolution block: clock, reset, stimulus and verdict
// depends on c33_pkg, c33_checker and the block itself
module tb_conv3x3_stride1_or_2_accumulate;
    import c33_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [12:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_operation = '0;
    logic [3:0]         i_tap_index = '0;
    logic signed [15:0] i_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_result_value;
    logic [6:0]         o_out_row;
    logic [6:0]         o_out_col;
    logic               o_plane_last;
    int                 fail_count;
    int                 pending;
    int                 item_count = 0;
    int                 burst_left = 0;

    conv3x3_stride1_or_2_accumulate u_dut (.*);

    c33_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_valid, .o_stall,
        .i_operation, .i_tap_index, .i_value, .o_valid, .i_stall, .o_result_value,
        .o_out_row, .o_out_col, .o_plane_last,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("FAIL conv3x3_stride1_or_2_accumulate");
        $finish;
    end

    // receiver stall pattern: free runs, random stalls and periodic long hold-offs
    initial begin
        int cyc;
        int next_hold;
        int n;
        cyc = 0;
        next_hold = 3000;
        forever begin
            n = $urandom_range(20, 200);
            if (cyc >= next_hold) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                cyc += 400;
                next_hold += 6000;
            end else if ($urandom_range(0, 2) == 0) begin
                i_stall <= 1'b0;
                repeat (n) @(posedge i_clk);
                cyc += n;
            end else begin
                repeat (n) begin
                    i_stall <= ($urandom_range(0, 2) == 0);
                    @(posedge i_clk);
                end
                cyc += n;
            end
        end
    end

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // one input transfer, then the burst and gap bookkeeping
    task automatic send(t_op op, logic [3:0] tap, logic signed [15:0] v);
        bit taken;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_tap_index <= tap;
        i_value     <= v;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        if (op != OP_NONE && !(op == OP_WEIGHT && tap >= C_TAPS)) item_count++;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 12)
                                                      : $urandom_range(40, 200);
        end else begin
            burst_left--;
        end
    endtask

    // drain all results and let the pipeline settle before touching config
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [12:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [7:0] w, logic [7:0] h, logic s, logic [12:0] ch);
        wait_idle();
        cfg_write(CFG_WIDTH, {5'($urandom), w});
        cfg_write(CFG_HEIGHT, {5'($urandom), h});
        cfg_write(CFG_STRIDE, {12'($urandom), s});
        cfg_write(CFG_CHANNELS, ch);
        i_cfg_we <= 1'b0;
    endtask

    // stream whole planes with occasional ignored or tap-update items mixed in
    task automatic stream_planes(int npix, int nplanes);
        for (int p = 0; p < nplanes; p++) begin
            for (int i = 0; i < npix; i++) begin
                if (item_count >= 1650) return;
                if ($urandom_range(0, 29) == 0) begin
                    case ($urandom_range(0, 2))
                        0: send(OP_NONE, 4'($urandom), 16'($urandom));
                        1: send(OP_WEIGHT, 4'($urandom_range(9, 15)), 16'($urandom));
                        default: send(OP_WEIGHT, 4'($urandom_range(0, 8)), rand_sample());
                    endcase
                end
                send(OP_PIXEL, 4'($urandom), rand_sample());
            end
        end
    endtask

    initial begin
        logic [7:0]  w;
        logic [7:0]  h;
        logic [12:0] ch;
        int          nch;
        int          nplanes;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest plane, saturation both ways, ignored items
        configure(8'd3, 8'd3, 1'b0, 13'd1);
        for (int t = 0; t < C_TAPS; t++) send(OP_WEIGHT, 4'(t), 16'sh7fff);
        send(OP_BIAS, 4'd0, 16'sh7fff);
        repeat (9) send(OP_PIXEL, 4'd0, 16'sh7fff);
        send(OP_NONE, 4'hf, 16'shffff);
        send(OP_WEIGHT, 4'hf, 16'sh0000);
        send(OP_BIAS, 4'd0, 16'sh8000);
        repeat (9) send(OP_PIXEL, 4'd0, 16'sh8000);

        // random phases of whole planes at varied sizes and settings
        while (item_count < 1650) begin
            case ($urandom_range(0, 19))
                0: begin w = 8'd128; h = 8'($urandom_range(3, 4)); end
                1: begin w = 8'($urandom_range(3, 4)); h = 8'd128; end
                2: begin w = 8'($urandom_range(0, 2)); h = 8'($urandom_range(0, 5)); end
                3: begin w = ($urandom_range(0, 1)) ? 8'd255 : 8'd200; h = 8'd3; end
                default: begin w = 8'($urandom_range(3, 9)); h = 8'($urandom_range(3, 9)); end
            endcase
            case ($urandom_range(0, 11))
                0: ch = 13'd0;
                1: ch = ($urandom_range(0, 1)) ? 13'd4096 : 13'd8191;
                default: ch = 13'($urandom_range(1, 3));
            endcase
            nch = clamp(int'(ch), 1, 4096);
            nplanes = (nch > 8) ? 1 : nch + ($urandom_range(0, 3) == 0);
            configure(w, h, 1'($urandom_range(0, 1)), ch);
            for (int t = 0; t < C_TAPS; t++) send(OP_WEIGHT, 4'(t), rand_sample());
            send(OP_BIAS, 4'($urandom), rand_sample());
            stream_planes(clamp(int'(w), 3, C_MAX_WIDTH) * clamp(int'(h), 3, C_MAX_HEIGHT),
                          nplanes);
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS conv3x3_stride1_or_2_accumulate");
        end else begin
            $display("FAIL conv3x3_stride1_or_2_accumulate");
        end
        $finish;
    end

endmodule
